FILE: hdl/crcfc_pkg.sv
`default_nettype none

package crcfc_pkg;

  localparam int unsigned FCS_BYTES = 4;
  localparam int unsigned FCS_IDX_W = 2;
  localparam int unsigned CNT_W     = 3;

  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOROUT    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY_REFL = 32'hEDB8_8320;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } crcfc_item_t;

  typedef struct packed {
    logic        crc_ok;
    logic        too_short;
    logic [31:0] computed_crc;
    logic [31:0] received_fcs;
    logic [31:0] frames_seen;
    logic [31:0] frames_good;
  } crcfc_result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY_REFL) : (r >> 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/crcfc_in_reg.sv
`default_nettype none

module crcfc_in_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 last_byte_i,
  input  wire logic                 adv_i,
  output logic                      item_valid_o,
  output crcfc_pkg::crcfc_item_t    item_o
);
  import crcfc_pkg::*;

  logic        valid_q;
  crcfc_item_t item_q;
  logic        take;

  assign in_stall_o   = valid_q && !adv_i;
  assign take         = in_valid_i && !in_stall_o;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (adv_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.data <= data_byte_i;
      item_q.last <= last_byte_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/crcfc_core.sv
`default_nettype none

module crcfc_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   adv_i,
  input  wire crcfc_pkg::crcfc_item_t item_i,
  output crcfc_pkg::crcfc_result_t    res_o
);
  import crcfc_pkg::*;

  logic [31:0]      crc_q, crc_d;
  logic [7:0]       hold_q [FCS_BYTES];
  logic [7:0]       hold_d [FCS_BYTES];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      seen_q, seen_d;
  logic [31:0]      good_q, good_d;
  logic             feed;
  logic             short_frame;
  logic             ok;
  logic [31:0]      computed;
  logic [31:0]      fcs;

  assign feed = (cnt_q >= CNT_W'(FCS_BYTES));

  always_comb begin
    hold_d = hold_q;
    if (feed) begin
      crc_d = crc_byte(crc_q, hold_q[0]);
      for (int i = 0; i < FCS_BYTES - 1; i++) begin
        hold_d[i] = hold_q[i+1];
      end
      hold_d[FCS_BYTES-1] = item_i.data;
      cnt_d = CNT_W'(FCS_BYTES);
    end else begin
      crc_d = crc_q;
      hold_d[cnt_q[FCS_IDX_W-1:0]] = item_i.data;
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_comb begin
    short_frame = (cnt_d < CNT_W'(FCS_BYTES));
    computed    = crc_d ^ CRC_XOROUT;
    fcs         = short_frame ? 32'd0 : {hold_d[3], hold_d[2], hold_d[1], hold_d[0]};
    ok          = !short_frame && (computed == fcs);
    seen_d      = seen_q + 32'd1;
    good_d      = good_q + {31'd0, ok};
  end

  assign res_o.crc_ok       = ok;
  assign res_o.too_short    = short_frame;
  assign res_o.computed_crc = computed;
  assign res_o.received_fcs = fcs;
  assign res_o.frames_seen  = seen_d;
  assign res_o.frames_good  = good_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CRC_INIT;
      cnt_q  <= '0;
      seen_q <= '0;
      good_q <= '0;
      for (int i = 0; i < FCS_BYTES; i++) begin
        hold_q[i] <= '0;
      end
    end else if (adv_i) begin
      if (item_i.last) begin
        crc_q  <= CRC_INIT;
        cnt_q  <= '0;
        seen_q <= seen_d;
        good_q <= good_d;
        for (int i = 0; i < FCS_BYTES; i++) begin
          hold_q[i] <= '0;
        end
      end else begin
        crc_q  <= crc_d;
        cnt_q  <= cnt_d;
        hold_q <= hold_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FCS_BYTES))
    else $error("held byte count out of range");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && item_i.last |=> cnt_q == '0 && crc_q == CRC_INIT)
    else $error("frame state not cleared after last byte");
`endif

endmodule

`default_nettype wire

FILE: hdl/crcfc_out_reg.sv
`default_nettype none

module crcfc_out_reg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     load_i,
  input  wire crcfc_pkg::crcfc_result_t res_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output crcfc_pkg::crcfc_result_t      res_o
);
  import crcfc_pkg::*;

  logic          valid_q;
  crcfc_result_t res_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("result word overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: hdl/crc32_frame_checker.sv
// Channel  Handshake                     Payload
// in       in_valid_i / in_stall_o       data_byte_i, last_byte_i
// out      out_valid_o / out_stall_i     crc_ok_o, too_short_o, computed_crc_o,
//                                        received_fcs_o, frames_seen_o, frames_good_o
//
// One byte per cycle unless a last byte waits; its verdict goes via in_reg, then out_reg.
// The byte-wide CRC update on the frame state, which also feeds the verdict, sets the path.
// Reset clears the frame state and both frame counters.
// A stalled output holds a last-marked byte while a verdict is pending; other bytes advance.
`default_nettype none

module crc32_frame_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             crc_ok_o,
  output logic             too_short_o,
  output logic [31:0]      computed_crc_o,
  output logic [31:0]      received_fcs_o,
  output logic [31:0]      frames_seen_o,
  output logic [31:0]      frames_good_o
);
  import crcfc_pkg::*;

  logic          item_valid;
  crcfc_item_t   item;
  logic          adv;
  logic          out_free;
  crcfc_result_t res_next;
  crcfc_result_t res;

  assign adv = item_valid && (!item.last || out_free);

  crcfc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .adv_i        (adv),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  crcfc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item),
    .res_o  (res_next)
  );

  crcfc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && item.last),
    .res_i       (res_next),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign crc_ok_o       = res.crc_ok;
  assign too_short_o    = res.too_short;
  assign computed_crc_o = res.computed_crc;
  assign received_fcs_o = res.received_fcs;
  assign frames_seen_o  = res.frames_seen;
  assign frames_good_o  = res.frames_good;

`ifndef SYNTHESIS
  a_short_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_short_o |-> !crc_ok_o && received_fcs_o == 32'd0)
    else $error("short frame reported as passing");
`endif

endmodule

`default_nettype wire

FILE: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit [31:0] CRC_SEED    = 32'hFFFF_FFFF;
  localparam bit [31:0] POLY_REFL   = 32'hEDB8_8320;
  localparam int        FCS_LEN     = 4;
  localparam int        TAIL_LEN    = 200;
  localparam int        RANDOM_GOAL = 1400;

  typedef enum {FRAME_GOOD, FRAME_CORRUPT, FRAME_RAW} frame_kind_e;
  typedef enum {FILL_RAND, FILL_ZERO, FILL_ONES} fill_e;

  typedef struct packed {
    bit [7:0] data;
    bit       last;
  } byte_word_t;

  typedef struct packed {
    bit        crc_ok;
    bit        too_short;
    bit [31:0] computed_crc;
    bit [31:0] received_fcs;
    bit [31:0] frames_seen;
    bit [31:0] frames_good;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       last_byte = 1'b0;
  logic       out_stall = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        crc_ok_o;
  logic        too_short_o;
  logic [31:0] computed_crc_o;
  logic [31:0] received_fcs_o;
  logic [31:0] frames_seen_o;
  logic [31:0] frames_good_o;

  byte_word_t pending_bytes[$];
  verdict_t   verdicts_due[$];
  byte_word_t next_word;
  int         gap_left = 0;
  int         stall_left = 0;
  bit         tail_phase = 1'b0;
  int         n_mismatch = 0;

  bit [31:0]     run_crc = CRC_SEED;
  bit [3:0][7:0] held_bytes = '0;
  bit [2:0]      held_n = '0;
  bit [31:0]     n_seen = '0;
  bit [31:0]     n_good = '0;

  crc32_frame_checker i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte),
    .last_byte_i    (last_byte),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .crc_ok_o       (crc_ok_o),
    .too_short_o    (too_short_o),
    .computed_crc_o (computed_crc_o),
    .received_fcs_o (received_fcs_o),
    .frames_seen_o  (frames_seen_o),
    .frames_good_o  (frames_good_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit [31:0] crc_step(input bit [31:0] c, input bit [7:0] b);
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ ({32{c[0] ^ b[i]}} & POLY_REFL);
    end
    return c;
  endfunction

  task automatic mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    n_mismatch++;
  endtask

  task automatic absorb_byte(input bit [7:0] b, input bit lst);
    verdict_t v;
    if (held_n == FCS_LEN) begin
      run_crc = crc_step(run_crc, held_bytes[0]);
      held_bytes = {b, held_bytes[3:1]};
    end else begin
      held_bytes[held_n[1:0]] = b;
      held_n++;
    end
    if (lst) begin
      v.too_short    = (held_n < FCS_LEN);
      v.computed_crc = ~run_crc;
      v.received_fcs = v.too_short ? 32'h0 : held_bytes;
      v.crc_ok       = !v.too_short && (v.computed_crc == v.received_fcs);
      n_seen++;
      if (v.crc_ok) n_good++;
      v.frames_seen = n_seen;
      v.frames_good = n_good;
      verdicts_due.push_back(v);
      run_crc = CRC_SEED;
      held_bytes = '0;
      held_n = '0;
    end
  endtask

  task automatic check_verdict();
    verdict_t e;
    if (verdicts_due.size() == 0) begin
      mismatch("verdict word with none expected");
    end else begin
      e = verdicts_due.pop_front();
      if (crc_ok_o !== e.crc_ok)
        mismatch($sformatf("crc_ok %b, expected %b", crc_ok_o, e.crc_ok));
      if (too_short_o !== e.too_short)
        mismatch($sformatf("too_short %b, expected %b", too_short_o, e.too_short));
      if (computed_crc_o !== e.computed_crc)
        mismatch($sformatf("computed_crc %h, expected %h", computed_crc_o, e.computed_crc));
      if (received_fcs_o !== e.received_fcs)
        mismatch($sformatf("received_fcs %h, expected %h", received_fcs_o, e.received_fcs));
      if (frames_seen_o !== e.frames_seen)
        mismatch($sformatf("frames_seen %0d, expected %0d", frames_seen_o, e.frames_seen));
      if (frames_good_o !== e.frames_good)
        mismatch($sformatf("frames_good %0d, expected %0d", frames_good_o, e.frames_good));
    end
  endtask

  task automatic queue_frame(input frame_kind_e kind, input int len, input fill_e fill);
    bit [7:0]  body[$];
    bit [31:0] c;
    bit [31:0] fcs;
    int        idx;
    byte_word_t w;
    for (int i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: body.push_back(8'h00);
        FILL_ONES: body.push_back(8'hFF);
        default:   body.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    if (kind != FRAME_RAW) begin
      c = CRC_SEED;
      foreach (body[i]) c = crc_step(c, body[i]);
      fcs = ~c;
      for (int i = 0; i < FCS_LEN; i++) body.push_back(fcs[8*i +: 8]);
    end
    if (kind == FRAME_CORRUPT) begin
      idx = $urandom_range(0, body.size() - 1);
      body[idx] ^= 8'(1 << $urandom_range(0, 7));
    end
    foreach (body[i]) begin
      w.data = body[i];
      w.last = (i == body.size() - 1);
      pending_bytes.push_back(w);
    end
  endtask

  // advance on accept, hold while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall_o) absorb_byte(data_byte, last_byte);
      if (!in_valid || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          next_word = pending_bytes.pop_front();
          in_valid  <= 1'b1;
          data_byte <= next_word.data;
          last_byte <= next_word.last;
          if (pending_bytes.size() > TAIL_LEN && $urandom_range(0, 11) == 0)
            gap_left = $urandom_range(1, 17);
        end else begin
          in_valid <= 1'b0;
        end
      end
      tail_phase <= (pending_bytes.size() <= TAIL_LEN);
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall) check_verdict();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!tail_phase && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 17);
      end
    end
  end

  initial begin
    int pick;
    queue_frame(FRAME_RAW, 1, FILL_ONES);
    queue_frame(FRAME_RAW, 2, FILL_RAND);
    queue_frame(FRAME_RAW, 3, FILL_ZERO);
    queue_frame(FRAME_GOOD, 0, FILL_ZERO);
    queue_frame(FRAME_RAW, 4, FILL_ONES);
    queue_frame(FRAME_GOOD, 1, FILL_ONES);
    queue_frame(FRAME_CORRUPT, 2, FILL_RAND);
    while (pending_bytes.size() < RANDOM_GOAL + 25) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        queue_frame(FRAME_GOOD,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24),
                    FILL_RAND);
      else if (pick < 85)
        queue_frame(FRAME_CORRUPT, $urandom_range(0, 24), FILL_RAND);
      else if (pick < 93)
        queue_frame(FRAME_RAW, $urandom_range(1, 3), FILL_RAND);
      else
        queue_frame(FRAME_RAW, $urandom_range(4, 30), FILL_RAND);
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_bytes.size() > 0 || in_valid) @(posedge clk_i);
    while (verdicts_due.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (n_mismatch == 0) begin
      $display("** crc32_frame_checker: PASSED **");
    end else begin
      $display("** crc32_frame_checker: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** crc32_frame_checker: FAILED **");
    $finish;
  end

endmodule
